// ===== rtl/gltg_pkg.sv =====
// ----------------------------------------------------------------------------
// gltg_pkg
// shared constants, register map and tables of the gait leg trajectory generator
// ----------------------------------------------------------------------------
package gltg_pkg;

	localparam int TIME_BITS_DEF   = 32;
	localparam int TRIG_ITER_DEF   = 16;
	localparam int MAX_TIME_BITS   = 64;
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 32;
	localparam int ATAN_ENTRIES    = 24;

	// trig datapath, signed Q5.24 with headroom
	localparam int TW = 29;
	// serial multiplier accumulator and operand b
	localparam int AW = 45;
	localparam int BW = 17;

	localparam logic [15:0] TRACE_START_Q13 = 16'd7725;
	localparam logic [15:0] TRACE_SPAN_Q13  = 16'd10289;
	localparam logic [15:0] PI_Q13          = 16'd25736;
	localparam logic signed [16:0] LIFT_Z_Q88 = 17'sd2560;

	localparam logic signed [TW-1:0] PI_Q24      = 29'sd52707179;
	localparam logic signed [TW-1:0] HALF_PI_Q24 = 29'sd26353589;
	localparam logic signed [TW-1:0] TWO_PI_Q24  = 29'sd105414358;
	localparam logic signed [TW-1:0] GAIN_INV_Q24 = 29'sd10188014;
	localparam logic signed [TW-1:0] ONE_Q24     = 29'sd16777216;

	localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214, 24'd524117, 24'd262123, 24'd131069,
		24'd65536, 24'd32768, 24'd16384, 24'd8192,
		24'd4096, 24'd2048, 24'd1024, 24'd512,
		24'd256, 24'd128, 24'd64, 24'd32,
		24'd16, 24'd8, 24'd4, 24'd2
	};

	typedef enum logic [2:0] {
		REG_PERIOD  = 3'd0,
		REG_PUSH    = 3'd1,
		REG_PUBLISH = 3'd2,
		REG_RADIUS  = 3'd3,
		REG_STEP    = 3'd4,
		REG_OFFSET  = 3'd5,
		REG_ANGLE   = 3'd6,
		REG_LEG     = 3'd7
	} reg_idx_t;

	localparam logic [15:0] RST_PERIOD  = 16'd10000;
	localparam logic [15:0] RST_PUSH    = 16'd39322;
	localparam logic [15:0] RST_PUBLISH = 16'd50;
	localparam logic [14:0] RST_RADIUS  = 15'd2560;
	localparam logic [14:0] RST_STEP    = 15'd3840;
	localparam logic [2:0]  RST_LEG     = 3'd1;

endpackage

// ===== rtl/gltg_in_if.sv =====
// ----------------------------------------------------------------------------
// gltg_in_if
// time stamp channel, one millisecond stamp per beat
// ----------------------------------------------------------------------------
interface gltg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink (input valid, input now_ms, output ready);
endinterface

// ===== rtl/gltg_out_if.sv =====
// ----------------------------------------------------------------------------
// gltg_out_if
// goal point channel, one transformed tip point per beat
// ----------------------------------------------------------------------------
interface gltg_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         leg_id;
	logic signed [15:0] goal_x;
	logic signed [15:0] goal_y;
	logic signed [15:0] goal_z;
	logic               is_stepping;

	modport source (output valid, output leg_id, output goal_x, output goal_y, output goal_z,
		output is_stepping, input ready);
	modport sink (input valid, input leg_id, input goal_x, input goal_y, input goal_z,
		input is_stepping, output ready);
endinterface

// ===== rtl/gait_leg_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// gait_leg_trajectory_generator
// per-leg walking gait tip point generator with apb register port
//
//   channel | dir | beat                        | handshake
//   stamp   | in  | now_ms                      | valid/ready
//   goal    | out | leg_id, goal_x/y/z, stepping| valid/ready
//   apb     | in  | register write / read       | psel/penable, pready high
//
// one stamp at a time; the rotation runs only when a point is published.
// the work runs through the bit-serial divider (one quotient bit a cycle),
// the shared cordic (one iteration a cycle) and the shift-add multiplier
// (one operand bit a cycle). an offset write in idle above the period runs
// a 20-step divide and a 17-step multiply before the next stamp is taken.
// a stalled goal beat holds only the final load; all work before it
// proceeds. async reset, no clear pass.
// ----------------------------------------------------------------------------
module gait_leg_trajectory_generator #(
	parameter int TIME_BITS       = gltg_pkg::TIME_BITS_DEF,
	parameter int TRIG_ITERATIONS = gltg_pkg::TRIG_ITER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gltg_in_if.sink                     stamp,
	gltg_out_if.source                  goal,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gltg_pkg::ADDR_W-1:0] paddr,
	input  logic [gltg_pkg::DATA_W-1:0] pwdata,
	output logic [gltg_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import gltg_pkg::*;

	localparam int TB = TIME_BITS;
	localparam int NS = 34;

	typedef enum logic [NS-1:0] {
		ST_IDLE      = 34'b1 << 0,
		ST_OFF_MUL   = 34'b1 << 1,
		ST_OFF_SET   = 34'b1 << 2,
		ST_CUR       = 34'b1 << 3,
		ST_ELAP      = 34'b1 << 4,
		ST_MAG       = 34'b1 << 5,
		ST_CLS       = 34'b1 << 6,
		ST_QDONE     = 34'b1 << 7,
		ST_PHASE     = 34'b1 << 8,
		ST_PUSH_FRAC = 34'b1 << 9,
		ST_PUSH_ANG  = 34'b1 << 10,
		ST_PUSH_X    = 34'b1 << 11,
		ST_PUSH_Y    = 34'b1 << 12,
		ST_PUSH_Z    = 34'b1 << 13,
		ST_STEP_S0   = 34'b1 << 14,
		ST_STEP_TH   = 34'b1 << 15,
		ST_STEP_SOFT = 34'b1 << 16,
		ST_STEP_ANG  = 34'b1 << 17,
		ST_STEP_D    = 34'b1 << 18,
		ST_STEP_X    = 34'b1 << 19,
		ST_STEP_Y0   = 34'b1 << 20,
		ST_STEP_Y1   = 34'b1 << 21,
		ST_STEP_Z    = 34'b1 << 22,
		ST_STEP_ZD   = 34'b1 << 23,
		ST_PUB       = 34'b1 << 24,
		ST_ROT       = 34'b1 << 25,
		ST_ROT_X1    = 34'b1 << 26,
		ST_ROT_GX    = 34'b1 << 27,
		ST_ROT_Y1    = 34'b1 << 28,
		ST_ROT_GY    = 34'b1 << 29,
		ST_EMIT      = 34'b1 << 30,
		ST_DIV       = 34'b1 << 31,
		ST_MUL       = 34'b1 << 32,
		ST_TRIG      = 34'b1 << 33
	} st_t;

	function automatic logic signed [15:0] to_q88(input logic signed [AW-1:0] v);
		logic signed [AW:0] r;
		logic signed [21:0] h;
		r = (AW+1)'(v) + (AW+1)'(25'sd8388608);
		h = 22'(r >>> 24);
		if (h > 22'sd32767)
			return 16'sh7fff;
		else if (h < -22'sd32768)
			return 16'sh8000;
		else
			return 16'(h);
	endfunction

	function automatic logic [15:0] arc_angle(input logic [16:0] f);
		logic [31:0] p;
		p = 32'(f) * 32'(TRACE_SPAN_Q13) + 32'd32768;
		return TRACE_START_Q13 + p[31:16];
	endfunction

	function automatic logic [15:0] ease_angle(input logic [15:0] f);
		logic [31:0] p;
		p = 32'(f) * 32'(PI_Q13) + 32'd32768;
		return p[31:16];
	endfunction

	function automatic logic [16:0] soften(input logic signed [TW-1:0] c);
		logic signed [TW-1:0] cc;
		logic signed [TW-1:0] s;
		logic [19:0] sh;
		if (c > ONE_Q24)
			cc = ONE_Q24;
		else if (c < -ONE_Q24)
			cc = -ONE_Q24;
		else
			cc = c;
		s = cc + ONE_Q24 + 29'sd256;
		sh = 20'(s >>> 9);
		if (sh > 20'd65536)
			return 17'h10000;
		else
			return sh[16:0];
	endfunction

	// registers
	logic [15:0] period_q, push_q, publish_q, angle_q;
	logic [14:0] radius_q, lift_q;
	logic [17:0] offset_q;
	logic [2:0]  leg_q;

	logic [TB-1:0] cs_q, last_q, now_q, cur_q, mag_q;
	logic          neg_q, step_q;
	logic signed [15:0] bx_q, by_q, bz_q, gx_q, gy_q;
	logic [15:0] qv_q;
	logic [16:0] frac_q;
	logic signed [TW-1:0] s0_q, d_q;

	st_t st_q, st_d, ret_q, ret_d;
	logic [4:0] cnt_q, cnt_i;

	// divider
	logic [16:0] rem_q, dvs_q;
	logic [19:0] dvd_q, quo_q;
	logic        div_go;
	logic [16:0] rem_i, dvs_i;
	logic [19:0] dvd_i;
	logic [17:0] div_t;
	logic        div_ge;

	// multiplier
	logic signed [AW-1:0] ma_q, acc_q, m_add;
	logic [BW-1:0]        mb_q;
	logic                 mneg_q, mul_go, mul_clr, mul_neg, m_sub;
	logic signed [TW-1:0] ma_i;
	logic [BW-1:0]        mb_i;

	// cordic
	logic signed [TW-1:0] tx_q, ty_q, tz_q, cos_q, sin_q;
	logic                 flip_q, trig_go;
	logic [15:0]          trig_a;
	logic signed [TW-1:0] z0, z1, z2, dx, dy, xn, yn, zn, at;
	logic                 fl;
	logic [4:0]           tidx;

	logic        wr;
	reg_idx_t    idx;
	logic [15:0] per;
	logic [TB-1:0] per_t, off_t, now_t, pub_t, elap;
	logic        out_load;
	logic signed [16:0] gz_sum;
	logic signed [15:0] gz;

	assign wr    = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign per   = (period_q == 16'd0) ? 16'd1 : period_q;
	assign per_t = TB'(MAX_TIME_BITS'(per));
	assign off_t = TB'(MAX_TIME_BITS'(offset_q));
	assign now_t = TB'(MAX_TIME_BITS'(stamp.now_ms));
	assign pub_t = TB'(MAX_TIME_BITS'(publish_q));
	assign elap  = TB'(cur_q - cs_q);

	assign stamp.ready = (st_q == ST_IDLE) && !wr;

	always_comb begin
		case (idx)
			REG_PERIOD:  prdata = DATA_W'(period_q);
			REG_PUSH:    prdata = DATA_W'(push_q);
			REG_PUBLISH: prdata = DATA_W'(publish_q);
			REG_RADIUS:  prdata = DATA_W'(radius_q);
			REG_STEP:    prdata = DATA_W'(lift_q);
			REG_OFFSET:  prdata = DATA_W'(offset_q);
			REG_ANGLE:   prdata = DATA_W'(angle_q);
			REG_LEG:     prdata = DATA_W'(leg_q);
			default:     prdata = '0;
		endcase
	end

	// divider step
	assign div_t  = {rem_q, dvd_q[19]};
	assign div_ge = div_t >= {1'b0, dvs_q};

	// multiplier step
	assign m_add = mb_q[0] ? ma_q : '0;
	assign m_sub = mneg_q ^ (cnt_q == 5'd0);

	// cordic setup and step
	always_comb begin
		z0 = {{2{trig_a[15]}}, trig_a, 11'b0};
		if (z0 > PI_Q24)
			z1 = z0 - TWO_PI_Q24;
		else if (z0 < -PI_Q24)
			z1 = z0 + TWO_PI_Q24;
		else
			z1 = z0;
		fl = 1'b0;
		if (z1 > HALF_PI_Q24) begin
			z2 = z1 - PI_Q24;
			fl = 1'b1;
		end else if (z1 < -HALF_PI_Q24) begin
			z2 = z1 + PI_Q24;
			fl = 1'b1;
		end else begin
			z2 = z1;
		end
	end

	assign tidx = 5'(TRIG_ITERATIONS - 1) - cnt_q;
	assign at   = TW'(ATAN_Q24[tidx]);
	assign dx   = ty_q >>> tidx;
	assign dy   = tx_q >>> tidx;
	assign xn   = (tz_q >= 0) ? tx_q - dx : tx_q + dx;
	assign yn   = (tz_q >= 0) ? ty_q + dy : ty_q - dy;
	assign zn   = (tz_q >= 0) ? tz_q - at : tz_q + at;

	assign gz_sum = 17'(bz_q) + LIFT_Z_Q88;
	assign gz     = (gz_sum > 17'sd32767) ? 16'sh7fff : 16'(gz_sum);
	assign out_load = (st_q == ST_EMIT) && (!goal.valid || goal.ready);

	always_comb begin
		st_d    = st_q;
		ret_d   = ret_q;
		cnt_i   = '0;
		div_go  = 1'b0;
		rem_i   = '0;
		dvd_i   = '0;
		dvs_i   = '0;
		mul_go  = 1'b0;
		mul_clr = 1'b0;
		mul_neg = 1'b0;
		ma_i    = '0;
		mb_i    = '0;
		trig_go = 1'b0;
		trig_a  = '0;
		case (st_q)
			ST_IDLE: begin
				if (wr && idx == REG_OFFSET && pwdata[17:0] > 18'(per)) begin
					div_go = 1'b1;
					dvd_i  = {1'b0, pwdata[17:0], 1'b0} + 20'(per);
					dvs_i  = {per, 1'b0};
					cnt_i  = 5'd19;
					ret_d  = ST_OFF_MUL;
					st_d   = ST_DIV;
				end else if (stamp.valid && stamp.ready) begin
					st_d = ST_CUR;
				end
			end
			ST_OFF_MUL: begin
				mul_go = 1'b1; mul_clr = 1'b1; mul_neg = 1'b1;
				ma_i = TW'(quo_q);
				mb_i = BW'(per);
				ret_d = ST_OFF_SET;
				st_d = ST_MUL;
			end
			ST_OFF_SET: st_d = ST_IDLE;
			ST_CUR: st_d = ST_ELAP;
			ST_ELAP: st_d = ST_MAG;
			ST_MAG: st_d = ST_CLS;
			ST_CLS: begin
				if (mag_q >= per_t) begin
					st_d = neg_q ? ST_PHASE : ST_PUB;
				end else begin
					div_go = 1'b1;
					rem_i = neg_q ? 17'(per - mag_q[15:0]) : 17'(mag_q[15:0]);
					dvs_i = 17'(per);
					cnt_i = 5'd15;
					ret_d = ST_QDONE;
					st_d = ST_DIV;
				end
			end
			ST_QDONE: st_d = ST_PHASE;
			ST_PHASE: begin
				if (qv_q == push_q) begin
					st_d = ST_PUSH_ANG;
				end else begin
					div_go = 1'b1;
					cnt_i = 5'd15;
					st_d = ST_DIV;
					if (qv_q < push_q) begin
						rem_i = 17'(qv_q);
						dvs_i = 17'(push_q);
						ret_d = ST_PUSH_FRAC;
					end else begin
						rem_i = 17'(qv_q - push_q);
						dvs_i = 17'h10000 - 17'(push_q);
						ret_d = ST_STEP_S0;
					end
				end
			end
			ST_PUSH_FRAC: st_d = ST_PUSH_ANG;
			ST_PUSH_ANG: begin
				trig_go = 1'b1;
				trig_a = arc_angle(frac_q);
				ret_d = ST_PUSH_X;
				st_d = ST_TRIG;
			end
			ST_PUSH_X, ST_STEP_X: begin
				mul_go = 1'b1; mul_clr = 1'b1;
				ma_i = cos_q;
				mb_i = BW'(radius_q);
				ret_d = (st_q == ST_PUSH_X) ? ST_PUSH_Y : ST_STEP_Y0;
				st_d = ST_MUL;
			end
			ST_PUSH_Y, ST_STEP_Y0: begin
				mul_go = 1'b1; mul_clr = 1'b1;
				ma_i = sin_q;
				mb_i = BW'(radius_q);
				ret_d = (st_q == ST_PUSH_Y) ? ST_PUSH_Z : ST_STEP_Y1;
				st_d = ST_MUL;
			end
			ST_PUSH_Z: st_d = ST_PUB;
			ST_STEP_S0: begin
				trig_go = 1'b1;
				trig_a = TRACE_START_Q13;
				ret_d = ST_STEP_TH;
				st_d = ST_TRIG;
			end
			ST_STEP_TH: begin
				trig_go = 1'b1;
				trig_a = ease_angle(frac_q[15:0]);
				ret_d = ST_STEP_SOFT;
				st_d = ST_TRIG;
			end
			ST_STEP_SOFT: st_d = ST_STEP_ANG;
			ST_STEP_ANG: begin
				trig_go = 1'b1;
				trig_a = arc_angle(frac_q);
				ret_d = ST_STEP_D;
				st_d = ST_TRIG;
			end
			ST_STEP_D: st_d = ST_STEP_X;
			ST_STEP_Y1: begin
				mul_go = 1'b1;
				ma_i = d_q;
				mb_i = BW'(lift_q);
				ret_d = ST_STEP_Z;
				st_d = ST_MUL;
			end
			ST_STEP_Z: begin
				mul_go = 1'b1; mul_clr = 1'b1; mul_neg = 1'b1;
				ma_i = d_q;
				mb_i = BW'(lift_q);
				ret_d = ST_STEP_ZD;
				st_d = ST_MUL;
			end
			ST_STEP_ZD: st_d = ST_PUB;
			ST_PUB: begin
				if (TB'(now_q - last_q) > pub_t) begin
					trig_go = 1'b1;
					trig_a = angle_q;
					ret_d = ST_ROT;
					st_d = ST_TRIG;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_ROT: begin
				mul_go = 1'b1; mul_clr = 1'b1;
				ma_i = cos_q;
				mb_i = BW'(bx_q);
				ret_d = ST_ROT_X1;
				st_d = ST_MUL;
			end
			ST_ROT_X1: begin
				mul_go = 1'b1; mul_neg = 1'b1;
				ma_i = sin_q;
				mb_i = BW'(by_q);
				ret_d = ST_ROT_GX;
				st_d = ST_MUL;
			end
			ST_ROT_GX: begin
				mul_go = 1'b1; mul_clr = 1'b1;
				ma_i = sin_q;
				mb_i = BW'(bx_q);
				ret_d = ST_ROT_Y1;
				st_d = ST_MUL;
			end
			ST_ROT_Y1: begin
				mul_go = 1'b1;
				ma_i = cos_q;
				mb_i = BW'(by_q);
				ret_d = ST_ROT_GY;
				st_d = ST_MUL;
			end
			ST_ROT_GY: st_d = ST_EMIT;
			ST_EMIT: if (out_load) st_d = ST_IDLE;
			ST_DIV, ST_MUL, ST_TRIG: if (cnt_q == 5'd0) st_d = ret_q;
			default: st_d = ST_IDLE;
		endcase
		if (mul_go)
			cnt_i = 5'(BW - 1);
		if (trig_go)
			cnt_i = 5'(TRIG_ITERATIONS - 1);
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ret_q     <= ST_IDLE;
			cnt_q     <= '0;
			period_q  <= RST_PERIOD;
			push_q    <= RST_PUSH;
			publish_q <= RST_PUBLISH;
			radius_q  <= RST_RADIUS;
			lift_q    <= RST_STEP;
			offset_q  <= '0;
			angle_q   <= '0;
			leg_q     <= RST_LEG;
			cs_q      <= '0;
			last_q    <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			bz_q      <= '0;
			goal.valid <= 1'b0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			if (div_go || mul_go || trig_go)
				cnt_q <= cnt_i;
			else if (cnt_q != 5'd0)
				cnt_q <= cnt_q - 5'd1;
			if (wr) begin
				case (idx)
					REG_PERIOD:  period_q  <= pwdata[15:0];
					REG_PUSH:    push_q    <= pwdata[15:0];
					REG_PUBLISH: publish_q <= pwdata[15:0];
					REG_RADIUS:  radius_q  <= pwdata[14:0];
					REG_STEP:    lift_q    <= pwdata[14:0];
					REG_OFFSET:  offset_q  <= pwdata[17:0];
					REG_ANGLE:   angle_q   <= pwdata[15:0];
					REG_LEG:     leg_q     <= pwdata[2:0];
					default: ;
				endcase
			end
			if (st_q == ST_IDLE && wr && idx == REG_OFFSET && !div_go)
				cs_q <= '0;
			if (st_q == ST_OFF_SET)
				cs_q <= TB'(MAX_TIME_BITS'(acc_q));
			if (st_q == ST_CLS && !neg_q && mag_q >= per_t)
				cs_q <= cur_q;
			if (st_q == ST_PUSH_Y || st_q == ST_STEP_Y0)
				bx_q <= to_q88(acc_q);
			if (st_q == ST_PUSH_Z || st_q == ST_STEP_Z)
				by_q <= to_q88(acc_q);
			if (st_q == ST_PUSH_Z)
				bz_q <= '0;
			if (st_q == ST_STEP_ZD)
				bz_q <= to_q88(acc_q);
			if (st_q == ST_PUB && trig_go)
				last_q <= now_q;
			if (out_load)
				goal.valid <= 1'b1;
			else if (goal.ready)
				goal.valid <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (stamp.valid && stamp.ready)
			now_q <= now_t;
		if (st_q == ST_CUR)
			cur_q <= TB'(now_q - off_t);
		if (st_q == ST_ELAP) begin
			mag_q <= elap;
			neg_q <= elap[TB-1];
		end
		if (st_q == ST_MAG && neg_q)
			mag_q <= TB'(~mag_q + 1'b1);
		if (st_q == ST_CLS) begin
			step_q <= !neg_q;
			if (mag_q >= per_t)
				qv_q <= '0;
		end
		if (st_q == ST_QDONE)
			qv_q <= quo_q[15:0];
		if (st_q == ST_PHASE) begin
			step_q <= qv_q > push_q;
			if (qv_q == push_q)
				frac_q <= (push_q == 16'd0) ? 17'd0 : 17'h10000;
		end
		if (st_q == ST_PUSH_FRAC || st_q == ST_STEP_S0)
			frac_q <= quo_q[16:0];
		if (st_q == ST_STEP_TH)
			s0_q <= sin_q;
		if (st_q == ST_STEP_SOFT)
			frac_q <= soften(cos_q);
		if (st_q == ST_STEP_D)
			d_q <= sin_q - s0_q;
		if (st_q == ST_ROT_GX)
			gx_q <= to_q88(acc_q);
		if (st_q == ST_ROT_GY)
			gy_q <= to_q88(acc_q);

		if (div_go) begin
			rem_q <= rem_i;
			dvd_q <= dvd_i;
			dvs_q <= dvs_i;
			quo_q <= '0;
		end else if (st_q == ST_DIV) begin
			rem_q <= div_ge ? 17'(div_t - 18'(dvs_q)) : div_t[16:0];
			dvd_q <= {dvd_q[18:0], 1'b0};
			quo_q <= {quo_q[18:0], div_ge};
		end

		if (mul_go) begin
			ma_q   <= AW'(ma_i);
			mb_q   <= mb_i;
			mneg_q <= mul_neg;
			if (mul_clr)
				acc_q <= '0;
		end else if (st_q == ST_MUL) begin
			acc_q <= m_sub ? acc_q - m_add : acc_q + m_add;
			ma_q  <= ma_q <<< 1;
			mb_q  <= mb_q >> 1;
		end

		if (trig_go) begin
			tx_q   <= GAIN_INV_Q24;
			ty_q   <= '0;
			tz_q   <= z2;
			flip_q <= fl;
		end else if (st_q == ST_TRIG) begin
			tx_q <= xn;
			ty_q <= yn;
			tz_q <= zn;
			if (cnt_q == 5'd0) begin
				cos_q <= flip_q ? -xn : xn;
				sin_q <= flip_q ? -yn : yn;
			end
		end

		if (out_load) begin
			goal.leg_id      <= leg_q;
			goal.goal_x      <= gx_q;
			goal.goal_y      <= gy_q;
			goal.goal_z      <= gz;
			goal.is_stepping <= step_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		stamp.valid && stamp.ready |=> st_q == ST_CUR)
		else $error("accepted stamp did not start work");
	a_beat_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(goal.valid) |-> $past(st_q == ST_EMIT))
		else $error("goal beat raised outside emit");
	a_trig_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_TRIG |-> cnt_q < 5'(TRIG_ITERATIONS))
		else $error("cordic count out of range");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> cnt_q < 5'd20)
		else $error("divider count out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !stamp.ready)
		else $error("stamp taken while busy");

endmodule

// ===== verif/gait_leg_trajectory_generator_test.sv =====
// ----------------------------------------------------------------------------
// gait_leg_trajectory_generator_test
// checks the goal points of one gait leg against a cycle-free predictor of the
// leg trace: register settings are written over apb while idle, time stamps
// are sent with random gaps, and each goal beat is compared with the oldest
// predicted point, with random and long stalls on the goal side
// ----------------------------------------------------------------------------
module gait_leg_trajectory_generator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gltg_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic [2:0]         leg_id;
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic signed [15:0] goal_z;
		logic               is_stepping;
	} goal_point_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	gltg_in_if  stamp_if ();
	gltg_out_if goal_if ();

	gait_leg_trajectory_generator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stamp   (stamp_if.sink),
		.goal    (goal_if.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// leg state mirror
	int unsigned period_ms, push_q16, publish_ms, radius_q88, lift_q88, offset_ms, leg_no;
	int angle_q13;
	logic [31:0] start_ms, emit_ms;
	longint base_x, base_y, base_z;

	goal_point_t expected_goals[$];
	int failures;
	int cycles;
	bit idle_on;
	int hold_cycles;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("gait_leg_trajectory_generator: mismatch");
			$finish;
		end
	end

	function automatic longint to_q88(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 23)) >>> 24;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	task automatic cordic(input int a_q13, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(a_q13) * 2048;
		x = GAIN_INV_Q24;
		y = 0;
		flip = 0;
		if (z > PI_Q24) z -= TWO_PI_Q24;
		else if (z < -PI_Q24) z += TWO_PI_Q24;
		if (z > HALF_PI_Q24) begin
			z -= PI_Q24;
			flip = 1;
		end else if (z < -HALF_PI_Q24) begin
			z += PI_Q24;
			flip = 1;
		end
		for (int i = 0; i < TRIG_ITER_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(ATAN_Q24[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(ATAN_Q24[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned live_period();
		return (period_ms == 0) ? 1 : period_ms;
	endfunction

	task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
		longint unsigned per, n;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PERIOD:  period_ms = value[15:0];
			REG_PUSH:    push_q16 = value[15:0];
			REG_PUBLISH: publish_ms = value[15:0];
			REG_RADIUS:  radius_q88 = value[14:0];
			REG_STEP:    lift_q88 = value[14:0];
			REG_OFFSET: begin
				offset_ms = value[17:0];
				per = live_period();
				n = 0;
				if (offset_ms > per) n = (2 * longint'(offset_ms) + per) / (2 * per);
				start_ms = 32'(0 - per * n);
			end
			REG_ANGLE:   angle_q13 = int'($signed(value[15:0]));
			REG_LEG:     leg_no = value[2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic leg_trace_step(input logic [31:0] now, output bit emitted,
		output goal_point_t g);
		longint unsigned per, r, q, mag, frac, sp, eased;
		logic [31:0] cur, e;
		bit restart, stepping;
		longint c, s, s0, cl, sl, d, rad, lift;
		int ang, th;
		per = live_period();
		r = push_q16;
		rad = radius_q88;
		lift = lift_q88;
		cur = now - offset_ms;
		e = cur - start_ms;
		q = 0;
		restart = 0;
		if (e[31]) begin
			mag = 32'(-e);
			q = (mag >= per) ? 0 : ((per - mag) << 16) / per;
		end else if (e >= per) begin
			restart = 1;
		end else begin
			q = (longint'(e) << 16) / per;
		end
		stepping = restart || q > r;
		if (restart) begin
			start_ms = cur;
		end else if (q <= r) begin
			frac = (r != 0) ? (q << 16) / r : 0;
			ang = TRACE_START_Q13 + int'((frac * TRACE_SPAN_Q13 + 32768) >> 16);
			cordic(ang, c, s);
			base_x = to_q88(rad * c);
			base_y = to_q88(rad * s);
			base_z = 0;
		end else begin
			sp = ((q - r) << 16) / (65536 - r);
			th = int'((sp * PI_Q13 + 32768) >> 16);
			cordic(th, c, s);
			if (c < -longint'(ONE_Q24)) c = -longint'(ONE_Q24);
			if (c > longint'(ONE_Q24)) c = ONE_Q24;
			eased = longint'(c + ONE_Q24 + 256) >>> 9;
			if (eased > 65536) eased = 65536;
			ang = TRACE_START_Q13 + int'((eased * TRACE_SPAN_Q13 + 32768) >> 16);
			cordic(ang, c, s);
			cordic(TRACE_START_Q13, cl, s0);
			d = s - s0;
			base_x = to_q88(rad * c);
			base_y = to_q88(rad * s + lift * d);
			base_z = to_q88(-lift * d);
		end
		emitted = 0;
		g = '0;
		if ((now - emit_ms) > 32'(publish_ms)) begin
			longint gz;
			emitted = 1;
			emit_ms = now;
			cordic(angle_q13, cl, sl);
			gz = base_z + LIFT_Z_Q88;
			if (gz > 32767) gz = 32767;
			g.leg_id = leg_no[2:0];
			g.goal_x = 16'(to_q88(cl * base_x - sl * base_y));
			g.goal_y = 16'(to_q88(sl * base_x + cl * base_y));
			g.goal_z = 16'(gz);
			g.is_stepping = stepping;
		end
	endtask

	task automatic send_stamp(input logic [31:0] t);
		bit emitted;
		goal_point_t g;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			stamp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		stamp_if.valid <= 1'b1;
		stamp_if.now_ms <= t;
		do @(posedge clk); while (!stamp_if.ready);
		leg_trace_step(t, emitted, g);
		if (emitted) expected_goals.push_back(g);
	endtask

	task automatic settle();
		stamp_if.valid <= 1'b0;
		while (expected_goals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// goal side: check each beat, then decide ready for the next cycle
	always @(posedge clk) begin
		goal_point_t want;
		if (arst_n && goal_if.valid && goal_if.ready) begin
			if (expected_goals.size() == 0) begin
				$error("goal beat with nothing expected");
				failures++;
			end else begin
				want = expected_goals.pop_front();
				if (goal_if.leg_id !== want.leg_id) begin
					$error("leg_id expected %0d got %0d", want.leg_id, goal_if.leg_id);
					failures++;
				end
				if (goal_if.goal_x !== want.goal_x) begin
					$error("goal_x expected %0d got %0d", want.goal_x, goal_if.goal_x);
					failures++;
				end
				if (goal_if.goal_y !== want.goal_y) begin
					$error("goal_y expected %0d got %0d", want.goal_y, goal_if.goal_y);
					failures++;
				end
				if (goal_if.goal_z !== want.goal_z) begin
					$error("goal_z expected %0d got %0d", want.goal_z, goal_if.goal_z);
					failures++;
				end
				if (goal_if.is_stepping !== want.is_stepping) begin
					$error("is_stepping expected %0d got %0d", want.is_stepping,
						goal_if.is_stepping);
					failures++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			goal_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			goal_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 14);
			goal_if.ready <= 1'b0;
		end else begin
			goal_if.ready <= 1'b1;
		end
	end

	task automatic run_stamps(input int count, input logic [31:0] first);
		logic [31:0] t;
		int unsigned per;
		t = first;
		per = 32'(live_period());
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: t = $urandom;
				1: t = t - $urandom_range(0, 2 * per);
				default: t = t + $urandom_range(1, (per / 8 > 1) ? per / 8 : 1);
			endcase
			send_stamp(t);
		end
	endtask

	task automatic test_reset_settings();
		logic [31:0] stamps [17] = '{0, 51, 120, 2000, 5999, 6100, 7000, 8500, 9900,
			10000, 10060, 25000, 24000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 40};
		foreach (stamps[i]) send_stamp(stamps[i]);
		settle();
	endtask

	task automatic test_register_extremes();
		set_register(REG_PERIOD, 0);
		set_register(REG_PUSH, 0);
		set_register(REG_PUBLISH, 0);
		set_register(REG_RADIUS, 32767);
		set_register(REG_STEP, 32767);
		set_register(REG_ANGLE, 32'(-25736));
		set_register(REG_LEG, 7);
		set_register(REG_OFFSET, 262143);
		for (int i = 0; i < 4; i++) send_stamp(32'(i * 3));
		settle();
		set_register(REG_PERIOD, 65535);
		set_register(REG_PUSH, 65535);
		set_register(REG_PUBLISH, 65535);
		set_register(REG_ANGLE, 25736);
		set_register(REG_OFFSET, 262143);
		send_stamp(32'd70000);
		send_stamp(32'd200000);
		send_stamp(32'd262100);
		send_stamp(32'd400000);
		settle();
		set_register(REG_PERIOD, 1);
		set_register(REG_PUSH, 1);
		set_register(REG_PUBLISH, 0);
		set_register(REG_OFFSET, 0);
		for (int i = 0; i < 4; i++) send_stamp(32'(500 + i));
		settle();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 7; ph++) begin
			idle_on = (ph < 6);
			set_register(REG_PERIOD, ($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(1, 3000));
			set_register(REG_PUSH, $urandom_range(0, 65535));
			set_register(REG_PUBLISH, ($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(0, 60));
			set_register(REG_RADIUS, $urandom_range(0, 32767));
			set_register(REG_STEP, $urandom_range(0, 32767));
			set_register(REG_ANGLE, 32'($signed($urandom_range(0, 51472)) - 25736));
			set_register(REG_LEG, $urandom_range(0, 7));
			set_register(REG_OFFSET, $urandom_range(0, 262143));
			if (ph == 2) hold_cycles = 3000;
			run_stamps(130, $urandom);
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stamp_if.valid = 1'b0;
		stamp_if.now_ms = '0;
		idle_on = 1;
		hold_cycles = 0;
		period_ms = RST_PERIOD;
		push_q16 = RST_PUSH;
		publish_ms = RST_PUBLISH;
		radius_q88 = RST_RADIUS;
		lift_q88 = RST_STEP;
		offset_ms = 0;
		angle_q13 = 0;
		leg_no = RST_LEG;
		start_ms = '0;
		emit_ms = '0;
		base_x = 0;
		base_y = 0;
		base_z = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_register_extremes();
		test_random_phases();
		if (failures == 0) begin
			$display("gait_leg_trajectory_generator: match");
		end else begin
			$display("gait_leg_trajectory_generator: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gltg_pkg.sv
rtl/gltg_in_if.sv
rtl/gltg_out_if.sv
rtl/gait_leg_trajectory_generator.sv
verif/gait_leg_trajectory_generator_test.sv
